// File: hw/rtl/quadrature_encoder_position_top_assert.svh
// assertion macros shared by the rtl files
`ifndef QUADRATURE_ENCODER_POSITION_TOP_ASSERT_SVH
`define QUADRATURE_ENCODER_POSITION_TOP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define QEP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qep assertion failed");

// condition holds in the cycle after the trigger
`define QEP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qep assertion failed");

`endif

// File: hw/rtl/qep_pkg.sv
package qep_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned TC_W    = 3;
    localparam int unsigned SPD_W   = 3;
    localparam int unsigned CFG_IDX_W = 3;

    // opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_DETENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIRECTION = 3'd4;

    // register reset values
    localparam logic signed [POS_W-1:0] RST_POSITION_MIN = 32'sd0;
    localparam logic signed [POS_W-1:0] RST_POSITION_MAX = 32'sd255;
    localparam logic [SPD_W-1:0]        RST_STEPS_PER_DETENT = 3'd1;

    typedef enum logic [1:0] {
        PH_STILL = 2'd0,
        PH_CW    = 2'd1,
        PH_CCW   = 2'd2
    } phase_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position_min;
        logic signed [POS_W-1:0] position_max;
        logic [SPD_W-1:0]        steps_per_detent;
        logic                    wrap_enable;
        logic                    invert_direction;
    } qep_cfg_t;

    typedef struct packed {
        logic                    last_a;
        logic                    last_b;
        phase_t                  phase;
        phase_t                  previous_phase;
        logic [TC_W-1:0]         transition_count;
        logic signed [POS_W-1:0] position;
    } qep_state_t;

    typedef struct packed {
        logic                    opcode;
        logic                    pin_a;
        logic                    pin_b;
        logic signed [POS_W-1:0] load_value;
    } qep_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    step_up;
        logic                    step_down;
        logic                    at_min;
        logic                    at_max;
    } qep_result_t;

endpackage

// File: hw/rtl/quadrature_encoder_position_top.sv
// quadrature encoder position counter
//
// input channel (in_valid / in_ready): one item per handshake, either a sample
// of the two encoder pins (opcode sample) or a preset of the position (opcode
// load, load_value). output channel (out_valid / out_ready): exactly one
// result item per input item, in order: position, step pulses, bound flags.
// configuration: cfg_write with cfg_index and cfg_data writes one register;
// only to be used while no item is in flight.
// an accepted item first waits in the input register, then moves to the result
// register, from which its result is offered.
// throughput: one item per cycle while the receiver keeps out_ready high, as the
// pin history, phase and position registers are updated once per item.
// stall: when the receiver holds out_ready low the result register holds and
// the input register still takes one more item; after that in_ready drops
// until the result is taken. no item is lost or repeated.
// reset: registers take their reset values, pin history goes to the pull-up
// idle level (both high), phase is still, position and count are zero, both
// channels empty.
`include "quadrature_encoder_position_top_assert.svh"

module quadrature_encoder_position_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_write,
    input  logic [qep_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qep_pkg::POS_W-1:0]           cfg_data,
    // input item channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic                                pin_a,
    input  logic                                pin_b,
    input  logic signed [qep_pkg::POS_W-1:0]    load_value,
    // result item channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [qep_pkg::POS_W-1:0]    position,
    output logic                                step_up,
    output logic                                step_down,
    output logic                                at_min,
    output logic                                at_max
);

    // configuration registers
    qep_pkg::qep_cfg_t    cfg_reg;

    // decoder state, updated once per item as it leaves the input register
    qep_pkg::qep_state_t  state_reg;
    qep_pkg::qep_state_t  state_next;

    // input register
    logic                 item_valid_reg;
    qep_pkg::qep_item_t   item_reg;

    // result register
    logic                 out_valid_reg;
    qep_pkg::qep_result_t result_reg;
    qep_pkg::qep_result_t result_next;

    logic                 advance;
    logic                 step_fire;

    // result register free or being emptied this cycle
    assign advance   = !out_valid_reg || out_ready;
    // input register free or moving on this cycle
    assign in_ready  = !item_valid_reg || advance;
    assign step_fire = item_valid_reg && advance;

    // configuration writes, bad detent values are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.position_min     <= qep_pkg::RST_POSITION_MIN;
            cfg_reg.position_max     <= qep_pkg::RST_POSITION_MAX;
            cfg_reg.steps_per_detent <= qep_pkg::RST_STEPS_PER_DETENT;
            cfg_reg.wrap_enable      <= 1'b0;
            cfg_reg.invert_direction <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                qep_pkg::REG_POSITION_MIN:
                    cfg_reg.position_min <= cfg_data;
                qep_pkg::REG_POSITION_MAX:
                    cfg_reg.position_max <= cfg_data;
                qep_pkg::REG_STEPS_PER_DETENT:
                begin
                    if (cfg_data[2:0] == 3'd1 || cfg_data[2:0] == 3'd2 ||
                        cfg_data[2:0] == 3'd4)
                        cfg_reg.steps_per_detent <= cfg_data[2:0];
                end
                qep_pkg::REG_WRAP_ENABLE:
                    cfg_reg.wrap_enable <= cfg_data[0];
                qep_pkg::REG_INVERT_DIRECTION:
                    cfg_reg.invert_direction <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.opcode     <= opcode;
            item_reg.pin_a      <= pin_a;
            item_reg.pin_b      <= pin_b;
            item_reg.load_value <= load_value;
        end
    end

    qep_step u_step
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.last_a           <= 1'b1;
            state_reg.last_b           <= 1'b1;
            state_reg.phase            <= qep_pkg::PH_STILL;
            state_reg.previous_phase   <= qep_pkg::PH_STILL;
            state_reg.transition_count <= '0;
            state_reg.position         <= '0;
        end
        else if (step_fire)
        begin
            state_reg <= state_next;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= item_valid_reg;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (step_fire)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign position  = result_reg.position;
    assign step_up   = result_reg.step_up;
    assign step_down = result_reg.step_down;
    assign at_min    = result_reg.at_min;
    assign at_max    = result_reg.at_max;

    // a result never steps both ways
    `QEP_ASSERT_IMPLY(a_one_direction, out_valid_reg, !(step_up && step_down))
    // while still the pin history is settled with both pins equal
    `QEP_ASSERT_IMPLY(a_still_settled, state_reg.phase == qep_pkg::PH_STILL,
                      state_reg.last_a == state_reg.last_b)
    // the completion count always stays below four
    `QEP_ASSERT_IMPLY(a_count_bound, 1'b1, state_reg.transition_count[2] == 1'b0)
    // a step closes the open phase
    `QEP_ASSERT_NEXT(a_step_closes, step_fire && (result_next.step_up || result_next.step_down),
                     state_reg.phase == qep_pkg::PH_STILL)

endmodule

// File: hw/rtl/qep_step.sv
// next-state and result logic for one item
module qep_step
(
    input  qep_pkg::qep_cfg_t    cfg,
    input  qep_pkg::qep_state_t  state,
    input  qep_pkg::qep_item_t   item,
    output qep_pkg::qep_state_t  state_next,
    output qep_pkg::qep_result_t result
);

    logic [qep_pkg::TC_W-1:0] tc;
    logic                     cw;
    logic                     up;
    logic                     down;

    always_comb
    begin
        state_next = state;
        tc         = state.transition_count;
        cw         = 1'b0;
        up         = 1'b0;
        down       = 1'b0;

        if (item.opcode == qep_pkg::OP_LOAD)
        begin
            state_next.position = item.load_value;
        end
        else if (state.phase == qep_pkg::PH_STILL)
        begin
            // a single pin change opens a phase, both changing is ignored
            if (item.pin_a != state.last_a && item.pin_b == state.last_b)
            begin
                state_next.last_a = item.pin_a;
                state_next.phase  = qep_pkg::PH_CCW;
            end
            else if (item.pin_a == state.last_a && item.pin_b != state.last_b)
            begin
                state_next.last_b = item.pin_b;
                state_next.phase  = qep_pkg::PH_CW;
            end
        end
        else if (item.pin_a == item.pin_b)
        begin
            state_next.last_a = item.pin_a;
            state_next.last_b = item.pin_b;
            if (state.phase == state.previous_phase)
                tc = state.transition_count + 3'd1;
            else
                tc = 3'd1;
            if (tc >= cfg.steps_per_detent)
            begin
                cw = (state.phase == qep_pkg::PH_CW) ^ cfg.invert_direction;
                if (cw)
                begin
                    up = 1'b1;
                    if ($signed(state.position) < $signed(cfg.position_max))
                        state_next.position = state.position + 32'sd1;
                    else if (cfg.wrap_enable)
                        state_next.position = cfg.position_min;
                end
                else
                begin
                    down = 1'b1;
                    if ($signed(state.position) > $signed(cfg.position_min))
                        state_next.position = state.position - 32'sd1;
                    else if (cfg.wrap_enable)
                        state_next.position = cfg.position_max;
                end
                tc = 3'd0;
            end
            state_next.transition_count = tc;
            state_next.previous_phase   = state.phase;
            state_next.phase            = qep_pkg::PH_STILL;
        end
    end

    assign result.position  = state_next.position;
    assign result.step_up   = up;
    assign result.step_down = down;
    assign result.at_min    = (state_next.position == cfg.position_min);
    assign result.at_max    = (state_next.position == cfg.position_max);

endmodule

// File: tb/quadrature_encoder_position_top_test.sv
`timescale 1ns / 1ps

module quadrature_encoder_position_top_test;

    // a result leaves through the input and result registers, so a short pause is enough to see the block idle
    localparam int unsigned SETTLE_CYCLES = 4;
    // longest receiver hold-off, used once to back the block up into its input
    localparam int unsigned LONG_HOLD     = 64;
    // cycles with no handshake on either side before the run is abandoned
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned PHASE_ITEMS   = 98;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;

    logic                             cfg_write = 1'b0;
    logic [qep_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [qep_pkg::POS_W-1:0]        cfg_data = '0;

    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic                             opcode = qep_pkg::OP_SAMPLE;
    logic                             pin_a = 1'b1;
    logic                             pin_b = 1'b1;
    logic signed [qep_pkg::POS_W-1:0] load_value = '0;

    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic signed [qep_pkg::POS_W-1:0] position;
    logic                             step_up;
    logic                             step_down;
    logic                             at_min;
    logic                             at_max;

    // own copy of the counter: registers and encoder state
    qep_pkg::qep_cfg_t                encoder_cfg;
    qep_pkg::qep_state_t              encoder_state;

    // items waiting to be offered, and results still owed by the block
    qep_pkg::qep_item_t               pending_items[$];
    qep_pkg::qep_result_t             expected_positions[$];

    // pin levels of the simulated encoder shaft, as last queued
    logic                             shaft_a = 1'b1;
    logic                             shaft_b = 1'b1;

    int unsigned                      items_queued = 0;
    int unsigned                      items_accepted = 0;
    int unsigned                      results_checked = 0;
    int unsigned                      mismatches = 0;
    int unsigned                      ups_seen = 0;
    int unsigned                      downs_seen = 0;
    int unsigned                      loads_sent = 0;
    int unsigned                      bound_hits = 0;
    int unsigned                      settings_used = 1;

    // idling controls, changed only while the block is idle
    bit                               sender_quiet = 1'b0;
    bit                               receiver_quiet = 1'b0;
    int unsigned                      stall_asked = 0;
    int unsigned                      stall_served = 0;

    int unsigned                      sender_gap = 0;
    int unsigned                      receiver_hold = 0;
    int unsigned                      idle_cycles = 0;

    quadrature_encoder_position_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .pin_a      (pin_a),
        .pin_b      (pin_b),
        .load_value (load_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .position   (position),
        .step_up    (step_up),
        .step_down  (step_down),
        .at_min     (at_min),
        .at_max     (at_max)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mostly back to back, sometimes a few cycles, now and then a long gap
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
        begin
            return 0;
        end
        else if (roll < 88)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 8);
    endfunction

    // one item through the counter: pin history, phase tracking, detent count, bounded position
    function automatic qep_pkg::qep_result_t advance_encoder(
        input logic op, input logic a, input logic b,
        input logic signed [qep_pkg::POS_W-1:0] value);
        qep_pkg::qep_result_t res;
        logic                 turn_cw;
        res = '0;
        if (op == qep_pkg::OP_LOAD)
        begin
            encoder_state.position = value;
        end
        else if (encoder_state.phase == qep_pkg::PH_STILL)
        begin
            // a lone edge on A opens a counter-clockwise phase, a lone edge on B a clockwise one
            if (a != encoder_state.last_a && b == encoder_state.last_b)
            begin
                encoder_state.last_a = a;
                encoder_state.phase  = qep_pkg::PH_CCW;
            end
            else if (a == encoder_state.last_a && b != encoder_state.last_b)
            begin
                encoder_state.last_b = b;
                encoder_state.phase  = qep_pkg::PH_CW;
            end
        end
        else if (a == b)
        begin
            // pins agree again: the phase completes
            encoder_state.last_a = a;
            encoder_state.last_b = b;
            if (encoder_state.phase == encoder_state.previous_phase)
            begin
                encoder_state.transition_count = encoder_state.transition_count + 3'd1;
            end
            else
            begin
                encoder_state.transition_count = 3'd1;
            end
            if (encoder_state.transition_count >= encoder_cfg.steps_per_detent)
            begin
                turn_cw = (encoder_state.phase == qep_pkg::PH_CW) ^
                          encoder_cfg.invert_direction;
                if (turn_cw)
                begin
                    res.step_up = 1'b1;
                    if ($signed(encoder_state.position) < $signed(encoder_cfg.position_max))
                    begin
                        encoder_state.position = encoder_state.position + 1;
                    end
                    else if (encoder_cfg.wrap_enable)
                    begin
                        encoder_state.position = encoder_cfg.position_min;
                    end
                end
                else
                begin
                    res.step_down = 1'b1;
                    if ($signed(encoder_state.position) > $signed(encoder_cfg.position_min))
                    begin
                        encoder_state.position = encoder_state.position - 1;
                    end
                    else if (encoder_cfg.wrap_enable)
                    begin
                        encoder_state.position = encoder_cfg.position_max;
                    end
                end
                encoder_state.transition_count = '0;
            end
            encoder_state.previous_phase = encoder_state.phase;
            encoder_state.phase          = qep_pkg::PH_STILL;
        end
        res.position = encoder_state.position;
        res.at_min   = (encoder_state.position == encoder_cfg.position_min);
        res.at_max   = (encoder_state.position == encoder_cfg.position_max);
        return res;
    endfunction

    // sender: offers the queued items, holds valid and payload until taken
    always @(posedge clk)
    begin : sender
        qep_pkg::qep_item_t next_item;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            sender_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                // payload still shows the item taken at this edge
                expected_positions.push_back(advance_encoder(opcode, pin_a, pin_b, load_value));
                items_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (sender_gap != 0)
                begin
                    sender_gap <= sender_gap - 1;
                    in_valid   <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    next_item  = pending_items.pop_front();
                    opcode     <= next_item.opcode;
                    pin_a      <= next_item.pin_a;
                    pin_b      <= next_item.pin_b;
                    load_value <= next_item.load_value;
                    in_valid   <= 1'b1;
                    sender_gap <= sender_quiet ? 0 : pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    always @(posedge clk)
    begin : receiver
        int unsigned gap;
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            receiver_hold <= 0;
        end
        else if (stall_asked != stall_served)
        begin
            stall_served  <= stall_asked;
            receiver_hold <= LONG_HOLD;
            out_ready     <= 1'b0;
        end
        else if (receiver_hold != 0)
        begin
            receiver_hold <= receiver_hold - 1;
            out_ready     <= 1'b0;
        end
        else
        begin
            gap = receiver_quiet ? 0 : pick_gap();
            if (gap == 0)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready     <= 1'b0;
                receiver_hold <= gap - 1;
            end
        end
    end

    function automatic void check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // checker: every result against the oldest expectation
    always @(posedge clk)
    begin : result_check
        qep_pkg::qep_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_positions.size() == 0)
            begin
                $error("result with no item outstanding: position %0d", position);
                mismatches++;
            end
            else
            begin
                want = expected_positions.pop_front();
                check_field("position", longint'($signed(want.position)), longint'(position));
                check_field("step_up", longint'(want.step_up), longint'(step_up));
                check_field("step_down", longint'(want.step_down), longint'(step_down));
                check_field("at_min", longint'(want.at_min), longint'(at_min));
                check_field("at_max", longint'(want.at_max), longint'(at_max));
                results_checked++;
                ups_seen   += want.step_up;
                downs_seen += want.step_down;
                bound_hits += (want.at_min || want.at_max);
            end
        end
    end

    // watchdog: a long spell with no handshake anywhere means the block has hung
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // register write, mirrored into the own copy; detent values other than 1, 2, 4 are dropped
    task automatic write_register(input logic [qep_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [qep_pkg::POS_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            qep_pkg::REG_POSITION_MIN: encoder_cfg.position_min = data;
            qep_pkg::REG_POSITION_MAX: encoder_cfg.position_max = data;
            qep_pkg::REG_STEPS_PER_DETENT:
            begin
                if (data[2:0] == 3'd1 || data[2:0] == 3'd2 || data[2:0] == 3'd4)
                begin
                    encoder_cfg.steps_per_detent = data[2:0];
                end
            end
            qep_pkg::REG_WRAP_ENABLE: encoder_cfg.wrap_enable = data[0];
            qep_pkg::REG_INVERT_DIRECTION: encoder_cfg.invert_direction = data[0];
            default: ;
        endcase
    endtask

    // a full set of writes, then a detent value the block must refuse
    task automatic configure(input logic [qep_pkg::POS_W-1:0] lo,
                             input logic [qep_pkg::POS_W-1:0] hi,
                             input logic [qep_pkg::POS_W-1:0] detent,
                             input logic [qep_pkg::POS_W-1:0] bad_detent,
                             input logic [qep_pkg::POS_W-1:0] wrap,
                             input logic [qep_pkg::POS_W-1:0] invert);
        write_register(qep_pkg::REG_POSITION_MIN, lo);
        write_register(qep_pkg::REG_POSITION_MAX, hi);
        write_register(qep_pkg::REG_STEPS_PER_DETENT, detent);
        write_register(qep_pkg::REG_WRAP_ENABLE, wrap);
        write_register(qep_pkg::REG_INVERT_DIRECTION, invert);
        write_register(qep_pkg::REG_STEPS_PER_DETENT, bad_detent);
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // pin sample; load_value carries noise that the block must ignore
    task automatic queue_sample(input logic a, input logic b);
        qep_pkg::qep_item_t it;
        it.opcode     = qep_pkg::OP_SAMPLE;
        it.pin_a      = a;
        it.pin_b      = b;
        it.load_value = $urandom();
        pending_items.push_back(it);
        shaft_a = a;
        shaft_b = b;
        items_queued++;
    endtask

    // position preset; the pins are random and must be ignored
    task automatic queue_load(input logic [qep_pkg::POS_W-1:0] value);
        qep_pkg::qep_item_t it;
        it.opcode     = qep_pkg::OP_LOAD;
        it.pin_a      = $urandom_range(1);
        it.pin_b      = $urandom_range(1);
        it.load_value = value;
        pending_items.push_back(it);
        items_queued++;
        loads_sent++;
    endtask

    // preset values near the current bounds, small numbers or anything at all
    function automatic logic [qep_pkg::POS_W-1:0] pick_position();
        case ($urandom_range(7))
            0: return encoder_cfg.position_min;
            1: return encoder_cfg.position_max;
            2: return encoder_cfg.position_min - 1;
            3: return encoder_cfg.position_max + 1;
            4: return encoder_cfg.position_min + 1;
            5: return encoder_cfg.position_max - 1;
            6: return 32'($urandom_range(16)) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    // well-formed gray-code turn of n transitions, with the odd contact bounce
    task automatic queue_turn(input bit cw, input int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++)
        begin
            if (shaft_a != shaft_b)
            begin
                queue_sample(shaft_a, shaft_a);
            end
            if (cw)
            begin
                queue_sample(shaft_a, !shaft_b);
            end
            else
            begin
                queue_sample(!shaft_a, shaft_b);
            end
            // bounce: the edge just taken flickers back and forth
            if ($urandom_range(5) == 0)
            begin
                if (cw)
                begin
                    queue_sample(shaft_a, !shaft_b);
                    queue_sample(shaft_a, !shaft_b);
                end
                else
                begin
                    queue_sample(!shaft_a, shaft_b);
                    queue_sample(!shaft_a, shaft_b);
                end
            end
            if (cw)
            begin
                queue_sample(!shaft_a, shaft_b);
            end
            else
            begin
                queue_sample(shaft_a, !shaft_b);
            end
        end
    endtask

    // mostly clean turns of random length and direction, some presets and glitches
    task automatic random_phase(input int unsigned count);
        int unsigned target;
        int unsigned roll;
        target = items_queued + count;
        while (items_queued < target)
        begin
            roll = $urandom_range(99);
            if (roll < 65)
            begin
                queue_turn($urandom_range(1), $urandom_range(9, 1));
            end
            else if (roll < 75)
            begin
                queue_load(pick_position());
            end
            else
            begin
                queue_sample($urandom_range(1), $urandom_range(1));
            end
        end
    endtask

    // wait for every item to be taken and answered, then let the pipeline settle
    task automatic wait_until_drained();
        while (items_accepted != items_queued || expected_positions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned p;

        // state after reset: pins idle high, still, bounds 0..255, one transition per step
        encoder_cfg.position_min       = qep_pkg::RST_POSITION_MIN;
        encoder_cfg.position_max       = qep_pkg::RST_POSITION_MAX;
        encoder_cfg.steps_per_detent   = qep_pkg::RST_STEPS_PER_DETENT;
        encoder_cfg.wrap_enable        = 1'b0;
        encoder_cfg.invert_direction   = 1'b0;
        encoder_state.last_a           = 1'b1;
        encoder_state.last_b           = 1'b1;
        encoder_state.phase            = qep_pkg::PH_STILL;
        encoder_state.previous_phase   = qep_pkg::PH_STILL;
        encoder_state.transition_count = '0;
        encoder_state.position         = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on the reset settings
        queue_sample(1'b1, 1'b1);   // no change at all
        queue_sample(1'b0, 1'b0);   // both pins move while still: ignored
        queue_sample(1'b1, 1'b0);   // B alone: clockwise phase opens
        queue_sample(1'b0, 1'b1);   // pins still differ: phase stays open
        queue_sample(1'b0, 1'b0);   // completes: step up
        queue_sample(1'b1, 1'b0);   // A alone: counter-clockwise
        queue_sample(1'b1, 1'b1);   // direction change restarts the count: step down
        queue_sample(1'b0, 1'b1);
        queue_sample(1'b0, 1'b0);   // step down at the lower bound holds
        queue_load(32'd255);
        queue_sample(1'b0, 1'b1);
        queue_sample(1'b1, 1'b1);   // step up at the upper bound holds
        queue_load(32'h7FFF_FFFF);
        queue_load(32'h8000_0000);
        queue_load(32'hFFFF_FFFF);
        queue_load(32'd128);
        queue_sample(1'b0, 1'b1);
        queue_sample(1'b0, 1'b0);
        queue_sample(1'b0, 1'b1);
        queue_sample(1'b1, 1'b1);
        wait_until_drained();

        // random phases over a spread of settings, extremes included
        for (p = 1; p <= 8; p++)
        begin
            sender_quiet   = (p == 3) || (p == 7);
            receiver_quiet = (p == 3);
            case (p)
                1: configure(-32'sd5, 32'sd5, 32'd2, 32'd3, 32'd1, 32'd0);
                2: configure(32'h8000_0000, 32'h7FFF_FFFF, 32'd4, 32'd0, 32'd0, 32'd1);
                // crossed bounds
                3: configure(32'sd10, -32'sd10, 32'd1, 32'd5, 32'd1, 32'd0);
                // upper bits of the data must be ignored
                4: configure(32'd0, 32'd0, 32'hFFFF_FFF9, 32'd6, 32'h0000_0002, 32'hFFFF_FFFF);
                5: configure(32'h8000_0000, 32'h8000_0006, 32'd2, 32'd7, 32'd1, 32'd1);
                6: configure(32'h7FFF_FFF8, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFB,
                             32'hFFFF_FFFF, 32'd0);
                7: configure(-32'sd1, 32'sd3, 32'd4, 32'd0, 32'd0, 32'd0);
                default: configure(-32'sd2, 32'sd2, 32'h0000_000A, 32'd3, 32'd1, 32'd1);
            endcase
            // receiver holds off while the sender keeps offering back to back
            if (p == 7)
            begin
                stall_asked++;
            end
            random_phase(PHASE_ITEMS);
            wait_until_drained();
        end

        if (expected_positions.size() != 0)
        begin
            $error("%0d results never arrived", expected_positions.size());
            mismatches++;
        end
        $display("run covered %0d items under %0d register settings, %0d results checked",
                 items_accepted, settings_used, results_checked);
        $display("steps up %0d, steps down %0d, presets %0d, results at a bound %0d",
                 ups_seen, downs_seen, loads_sent, bound_hits);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
